FILE: rtl/tslk_pkg.sv
// Shared types and constants for the touch screen lock policy block.
package tslk_pkg;

  // Field widths.
  localparam int unsigned TS_W   = 48;
  localparam int unsigned HOLD_W = 16;

  // Register reset value and default contact limit.
  localparam logic [HOLD_W-1:0] HOLD_TIME_RESET      = 16'd1000;
  localparam int unsigned       MAX_CONTACTS_DEFAULT = 15;

  // Event codes.
  localparam logic [1:0] ACT_PRESS   = 2'd0;
  localparam logic [1:0] ACT_RELEASE = 2'd1;
  localparam logic [1:0] ACT_CONTACT = 2'd2;
  localparam logic [1:0] ACT_POWER   = 2'd3;

  // Lock state codes as seen on the result channel.
  localparam logic [1:0] LS_UNLOCKED = 2'd0;
  localparam logic [1:0] LS_LOCKED   = 2'd1;
  localparam logic [1:0] LS_BLANKED  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [1:0]      action;
    logic [TS_W-1:0] timestamp;
    logic            contact_down;
  } tslk_item_t;

  // One result item.
  typedef struct packed {
    logic       took_effect;
    logic [1:0] lock_state;
    logic       touch_allowed;
  } tslk_result_t;

endpackage

FILE: rtl/tslk_policy.sv
// Lock policy state and the single-pass update for one item.
module tslk_policy #(
  parameter int unsigned MAX_CONTACTS = tslk_pkg::MAX_CONTACTS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [tslk_pkg::HOLD_W-1:0]    cfg_wr_data,
  input  logic                           step,
  input  tslk_pkg::tslk_item_t           item,
  output tslk_pkg::tslk_result_t         result
);
  import tslk_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_CONTACTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_CONTACTS);

  typedef enum logic [1:0] {
    UNLOCKED = LS_UNLOCKED,
    LOCKED   = LS_LOCKED,
    BLANKED  = LS_BLANKED
  } mode_t;

  mode_t             mode, mode_next;
  logic [TS_W-1:0]   hold_start, hold_start_next;
  logic [CNT_W-1:0]  finger_count, finger_count_next;
  logic              wait_all_up, wait_all_up_next;
  logic [HOLD_W-1:0] hold_time;
  logic              fired;

  // Elapsed hold: a borrow means the release came before the press.
  logic [TS_W:0]     elapsed;
  logic              long_enough;

  assign elapsed     = {1'b0, item.timestamp} - {1'b0, hold_start};
  assign long_enough = !elapsed[TS_W] &&
                       (elapsed[TS_W-1:0] >= {{(TS_W-HOLD_W){1'b0}}, hold_time});

  // Next state for the item in hand.
  always_comb begin
    mode_next         = mode;
    hold_start_next   = hold_start;
    finger_count_next = finger_count;
    wait_all_up_next  = wait_all_up;
    fired             = 1'b0;
    unique case (item.action)
      ACT_PRESS: begin
        if (mode != BLANKED) begin
          hold_start_next = (item.timestamp != '0) ? item.timestamp : TS_W'(1);
        end
      end
      ACT_RELEASE: begin
        if (mode != BLANKED && hold_start != '0) begin
          hold_start_next = '0;
          if (mode == UNLOCKED) begin
            mode_next = LOCKED;
            fired     = 1'b1;
          end else if (long_enough) begin
            mode_next        = UNLOCKED;
            wait_all_up_next = (finger_count != '0);
            fired            = 1'b1;
          end
        end
      end
      ACT_CONTACT: begin
        if (item.contact_down) begin
          if (finger_count != CNT_MAX) begin
            finger_count_next = finger_count + CNT_W'(1);
          end
        end else if (finger_count != '0) begin
          finger_count_next = finger_count - CNT_W'(1);
        end
        if (finger_count_next == '0) begin
          wait_all_up_next = 1'b0;
        end
      end
      ACT_POWER: begin
        if (mode == BLANKED) begin
          mode_next        = LOCKED;
          wait_all_up_next = (finger_count != '0);
        end else begin
          mode_next = BLANKED;
        end
        hold_start_next = '0;
        fired           = 1'b1;
      end
      default: begin
        mode_next = mode;
      end
    endcase
  end

  // Result reflects the state after the item.
  assign result.took_effect   = fired;
  assign result.lock_state    = mode_next;
  assign result.touch_allowed = (mode_next == UNLOCKED) && !wait_all_up_next;

  // Policy state, updated when the item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= UNLOCKED;
      hold_start   <= '0;
      finger_count <= '0;
      wait_all_up  <= 1'b0;
    end else if (step) begin
      mode         <= mode_next;
      hold_start   <= hold_start_next;
      finger_count <= finger_count_next;
      wait_all_up  <= wait_all_up_next;
    end
  end

  // Hold time register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_time <= HOLD_TIME_RESET;
    end else if (cfg_wr_en) begin
      hold_time <= cfg_wr_data;
    end
  end

endmodule

FILE: rtl/touch_screen_lock_fsm_unit.sv
// Top level of the touch screen lock policy block.
//
// Input channel: in_valid/in_ready carry one event item (action, timestamp,
// contact_down). Output channel: out_valid/out_ready carry one result item
// (took_effect, lock_state, touch_allowed) for every event, in order.
// An accepted item lands in an input register; in the next cycle the policy
// logic evaluates it against the current state and, as the result register
// takes it, the state is updated. While out_ready is high, one item per
// cycle is sustained: the path from the input register to the result
// register is one 48-bit subtract and compare.
// When the receiver stalls, the result register holds its item, the input
// register holds one more, and in_ready drops only once both are full.
// The hold time register is written through cfg_wr_en/cfg_wr_data
// with no handshake; write it only while no items are in flight.
// Reset (rst, synchronous) empties both registers, returns to unlocked with
// no hold, no fingers counted, and sets the hold time to 1000 ms.
module touch_screen_lock_fsm_unit #(
  parameter int unsigned MAX_CONTACTS = tslk_pkg::MAX_CONTACTS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [tslk_pkg::HOLD_W-1:0]   cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    action,
  input  logic [tslk_pkg::TS_W-1:0]     timestamp,
  input  logic                          contact_down,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          took_effect,
  output logic [1:0]                    lock_state,
  output logic                          touch_allowed
);
  import tslk_pkg::*;

  logic         s1_valid;
  tslk_item_t   s1_item;
  tslk_result_t step_result;
  tslk_result_t out_result;
  logic         advance;

  // The input register moves on when the result register is free or emptying.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item.action       <= action;
      s1_item.timestamp    <= timestamp;
      s1_item.contact_down <= contact_down;
    end
  end

  tslk_policy #(
    .MAX_CONTACTS(MAX_CONTACTS)
  ) u_policy (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .step       (advance),
    .item       (s1_item),
    .result     (step_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= step_result;
    end
  end

  assign took_effect   = out_result.took_effect;
  assign lock_state    = out_result.lock_state;
  assign touch_allowed = out_result.touch_allowed;

endmodule

FILE: rtl/tslk_checker.sv
// Port-level checks for the touch screen lock policy block, bound to the top.
module tslk_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          took_effect,
  input logic [1:0]                    lock_state,
  input logic                          touch_allowed
);
  import tslk_pkg::*;

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(took_effect) &&
      $stable(lock_state) && $stable(touch_allowed))
    else $error("result changed while stalled");

  // Touches are only allowed while unlocked.
  a_touch_unlocked: assert property (@(posedge clk) disable iff (rst)
    out_valid && touch_allowed |-> lock_state == LS_UNLOCKED)
    else $error("touch allowed outside unlocked state");

  // The input side only stalls behind a stalled result.
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

  // Nothing is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind touch_screen_lock_fsm_unit tslk_checker u_tslk_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .took_effect  (took_effect),
  .lock_state   (lock_state),
  .touch_allowed(touch_allowed)
);
